>>> hdl/efd_pkg.sv
// shared constants, types and arithmetic helpers for the error diffusion dither
// depends on nothing; used by every other file of the block but efd_ram
`default_nettype none

package efd_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int LUMA_W       = 8;
    localparam int ERR_W        = 14;
    localparam int SUM_W        = ERR_W + 3;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 8;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // 127.5 levels and full white, in 1/16 level units
    localparam err_t THRESHOLD   = ERR_W'(2040);
    localparam err_t WHITE_LEVEL = ERR_W'(4080);

    localparam sum_t SUM_ERR_MAX = SUM_W'((2 ** (ERR_W - 1)) - 1);
    localparam sum_t SUM_ERR_MIN = -SUM_W'(2 ** (ERR_W - 1));

    // diffusion weights in sixteenths
    localparam logic [2:0] WGT_RIGHT      = 3'd7;
    localparam logic [2:0] WGT_BELOW_LEFT = 3'd3;
    localparam logic [2:0] WGT_BELOW      = 3'd5;
    localparam logic [2:0] WGT_BELOW_RIGHT = 3'd1;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    function automatic err_t sat_err(input sum_t v);
        err_t r;
        if (v > SUM_ERR_MAX) begin
            r = SUM_ERR_MAX[ERR_W-1:0];
        end else if (v < SUM_ERR_MIN) begin
            r = SUM_ERR_MIN[ERR_W-1:0];
        end else begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

    // floor(e * wgt / 16)
    function automatic err_t share(input err_t e, input logic [2:0] wgt);
        sum_t p;
        p = SUM_W'(e) * $signed({1'b0, wgt});
        p = p >>> 4;
        return p[ERR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/efd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module efd_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/error_diffusion_dither_top.sv
// top level of the floyd-steinberg error diffusion dither
// depends on efd_pkg and efd_ram
`default_nettype none

// usage
//   s_ channel: one 8-bit luminance pixel per beat, raster order, s_tdata[7:0]
//   m_ channel: one dithered bit per pixel in m_tdata[0]; m_tlast marks the
//     last pixel of a row, m_tuser the last pixel of the frame
//   apb port: register 0 at 0x0 is image_width (11 bits), register 1 at 0x4
//     is image_height (13 bits); write them only while the block is idle
// throughput: one pixel per clock unless the result side stalls; right-neighbor
//   error returns via right_carry_reg; row error memory is read one column ahead
// latency: a result beat is valid the cycle after its pixel beat is taken
// stall: the result sits in an output register; while it is not taken the
//   input channel stays open only if the register drains in the same cycle
// reset: aresetn (synchronous, active low) clears position counters, carried
//   errors and the output valid flag, and loads width 640 and height 480;
//   the row error memory is not cleared and needs no clearing pass, since
//   the first row of a frame never reads it
// memory: one 14-bit x 1024 ram; the last error of a row is written from a
//   tail register in the cycle after its pixel, and recent writes are forwarded
module error_diffusion_dither_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input pixels
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [efd_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] luma
    // dithered output
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [efd_pkg::M_TDATA_W-1:0]    m_tdata,   // [0] out_bit, [7:1] zero
    output logic                                  m_tlast,   // end_of_row
    output logic                                  m_tuser,   // [0] end_of_frame
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [efd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [efd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [efd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);

    // configuration registers
    logic [efd_pkg::WIDTH_REG_W-1:0]  image_width_reg;
    logic [efd_pkg::HEIGHT_REG_W-1:0] image_height_reg;
    logic                             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= efd_pkg::WIDTH_RESET;
            image_height_reg <= efd_pkg::HEIGHT_RESET;
        end else if (cfg_write) begin
            case (efd_pkg::reg_idx_t'(paddr[2]))
                efd_pkg::REG_IMAGE_WIDTH: begin
                    image_width_reg <= pwdata[efd_pkg::WIDTH_REG_W-1:0];
                end
                efd_pkg::REG_IMAGE_HEIGHT: begin
                    image_height_reg <= pwdata[efd_pkg::HEIGHT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (efd_pkg::reg_idx_t'(paddr[2]))
            efd_pkg::REG_IMAGE_WIDTH: begin
                prdata = efd_pkg::APB_DATA_W'(image_width_reg);
            end
            efd_pkg::REG_IMAGE_HEIGHT: begin
                prdata = efd_pkg::APB_DATA_W'(image_height_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // position and carried error state
    logic [efd_pkg::COL_W-1:0] col_reg, col_next;
    logic [efd_pkg::ROW_W-1:0] row_reg;
    efd_pkg::err_t             right_carry_reg;
    efd_pkg::err_t             pend_bl_reg;     // pending below-left
    efd_pkg::err_t             pend_b_reg;      // pending below

    // tail write: last column error of a row, written the following cycle
    logic                      tail_valid_reg;
    logic [efd_pkg::COL_W-1:0] tail_addr_reg;
    efd_pkg::err_t             tail_data_reg;

    // forwarding of a write that hit the read address at the same edge
    logic                      fwd_hit_reg;
    efd_pkg::err_t             fwd_data_reg;

    // output register
    logic out_valid_reg, out_valid_next;
    logic out_bit_reg;
    logic out_eor_reg;
    logic out_eof_reg;

    logic accept;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // effective geometry, out of range values clamped
    logic [efd_pkg::WIDTH_REG_W-1:0]  w_eff;
    logic [efd_pkg::HEIGHT_REG_W-1:0] h_eff;
    logic [efd_pkg::COL_W:0]          col_plus;
    logic [efd_pkg::ROW_W:0]          row_plus;
    logic                             last_col, last_row, first_row;

    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = efd_pkg::WIDTH_REG_W'(1);
        end else if (image_width_reg > efd_pkg::WIDTH_REG_W'(efd_pkg::MAX_WIDTH)) begin
            w_eff = efd_pkg::WIDTH_REG_W'(efd_pkg::MAX_WIDTH);
        end else begin
            w_eff = image_width_reg;
        end
        if (image_height_reg == '0) begin
            h_eff = efd_pkg::HEIGHT_REG_W'(1);
        end else if (image_height_reg > efd_pkg::HEIGHT_REG_W'(efd_pkg::MAX_HEIGHT)) begin
            h_eff = efd_pkg::HEIGHT_REG_W'(efd_pkg::MAX_HEIGHT);
        end else begin
            h_eff = image_height_reg;
        end
    end

    assign col_plus  = {1'b0, col_reg} + 1'b1;
    assign row_plus  = {1'b0, row_reg} + 1'b1;
    assign last_col  = efd_pkg::WIDTH_REG_W'(col_plus) >= w_eff;
    assign last_row  = efd_pkg::HEIGHT_REG_W'(row_plus) >= h_eff;
    assign first_row = (row_reg == '0);

    // row error memory
    logic                      ram_we;
    logic [efd_pkg::COL_W-1:0] ram_waddr;
    efd_pkg::err_t             ram_wdata;
    logic [efd_pkg::ERR_W-1:0] ram_rdata;
    efd_pkg::err_t             mem_err;

    efd_ram #(
        .WIDTH (efd_pkg::ERR_W),
        .DEPTH (efd_pkg::MAX_WIDTH)
    ) u_row_err (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (col_next),
        .rdata (ram_rdata)
    );

    // newest value of the entry for the current column
    always_comb begin
        if (tail_valid_reg && (tail_addr_reg == col_reg)) begin
            mem_err = tail_data_reg;
        end else if (fwd_hit_reg) begin
            mem_err = fwd_data_reg;
        end else begin
            mem_err = $signed(ram_rdata);
        end
    end

    // pixel datapath
    efd_pkg::err_t above;
    efd_pkg::sum_t pix_sum;
    efd_pkg::err_t pix_val;
    logic          pix_bit;
    efd_pkg::err_t quant_err;
    efd_pkg::err_t sh_right, sh_bl, sh_b, sh_br;
    efd_pkg::err_t bl_entry;    // finished entry for column j-1
    efd_pkg::err_t pend_bl_new;

    always_comb begin
        above     = first_row ? '0 : mem_err;
        pix_sum   = efd_pkg::SUM_W'($signed({1'b0, s_tdata[efd_pkg::LUMA_W-1:0], 4'b0000}))
                  + efd_pkg::SUM_W'(right_carry_reg)
                  + efd_pkg::SUM_W'(above);
        pix_val   = efd_pkg::sat_err(pix_sum);
        pix_bit   = pix_val > efd_pkg::THRESHOLD;
        quant_err = pix_bit ? pix_val - efd_pkg::WHITE_LEVEL : pix_val;
        sh_right  = efd_pkg::share(quant_err, efd_pkg::WGT_RIGHT);
        sh_bl     = efd_pkg::share(quant_err, efd_pkg::WGT_BELOW_LEFT);
        sh_b      = efd_pkg::share(quant_err, efd_pkg::WGT_BELOW);
        sh_br     = efd_pkg::share(quant_err, efd_pkg::WGT_BELOW_RIGHT);
        bl_entry  = efd_pkg::sat_err(efd_pkg::SUM_W'(pend_bl_reg) + efd_pkg::SUM_W'(sh_bl));
        pend_bl_new = efd_pkg::sat_err(efd_pkg::SUM_W'(pend_b_reg) + efd_pkg::SUM_W'(sh_b));
    end

    // write port: tail write never meets a pixel write, the pixel after a
    // row end is in column zero and writes nothing
    logic pix_we;
    assign pix_we = accept && !last_row && (col_reg != '0);

    always_comb begin
        if (tail_valid_reg) begin
            ram_we    = 1'b1;
            ram_waddr = tail_addr_reg;
            ram_wdata = tail_data_reg;
        end else begin
            ram_we    = pix_we;
            ram_waddr = col_reg - 1'b1;
            ram_wdata = bl_entry;
        end
    end

    // read address runs one column ahead of the pixel being taken
    always_comb begin
        if (accept) begin
            col_next = last_col ? '0 : col_plus[efd_pkg::COL_W-1:0];
        end else begin
            col_next = col_reg;
        end
    end

    always_comb begin
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            row_reg         <= '0;
            right_carry_reg <= '0;
            pend_bl_reg     <= '0;
            pend_b_reg      <= '0;
            tail_valid_reg  <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            col_reg        <= col_next;
            out_valid_reg  <= out_valid_next;
            fwd_hit_reg    <= ram_we && (ram_waddr == col_next);
            tail_valid_reg <= accept && !last_row && last_col;
            if (accept) begin
                if (last_col) begin
                    right_carry_reg <= '0;
                    pend_bl_reg     <= '0;
                    pend_b_reg      <= '0;
                    row_reg         <= last_row ? '0 : row_plus[efd_pkg::ROW_W-1:0];
                end else begin
                    right_carry_reg <= sh_right;
                    if (!last_row) begin
                        pend_bl_reg <= pend_bl_new;
                        pend_b_reg  <= sh_br;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        fwd_data_reg  <= ram_wdata;
        tail_addr_reg <= col_reg;
        tail_data_reg <= pend_bl_new;
        if (accept) begin
            out_bit_reg <= pix_bit;
            out_eor_reg <= last_col;
            out_eof_reg <= last_col && last_row;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = efd_pkg::M_TDATA_W'(out_bit_reg);
    assign m_tlast  = out_eor_reg;
    assign m_tuser  = out_eof_reg;

endmodule

`default_nettype wire

>>> hdl/efd_checker.sv
// port-level checks for the error diffusion dither, bound to the top level
// depends on efd_pkg and error_diffusion_dither_top
`default_nettype none

module efd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [efd_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast,
    input wire logic                          m_tuser
);

    // a held result beat stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // the frame end is always also a row end
    a_eof_eor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of frame without end of row");

    // no result beat right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // a new result beat always follows a pixel beat
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !$past(m_tvalid && !m_tready) |-> $past(s_tvalid && s_tready))
        else $error("result beat without a pixel beat");

    // an empty output register never blocks the input, pad bits stay zero
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid |-> s_tready) and (m_tvalid |-> m_tdata[efd_pkg::M_TDATA_W-1:1] == '0))
        else $error("input blocked with empty output or pad bits set");

endmodule

bind error_diffusion_dither_top efd_checker u_efd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/sv/tb.sv
// self-checking bench for the error diffusion dither: apb register setup, pixel beats in,
// dithered beats out, each checked against a bit-true floyd-steinberg predictor
// depends on efd_pkg and error_diffusion_dither_top
`default_nettype none

module tb;

    localparam int ERR_HI = 2 ** (efd_pkg::ERR_W - 1) - 1;
    localparam int ERR_LO = -(2 ** (efd_pkg::ERR_W - 1));

    typedef struct packed {
        logic out_bit;
        logic end_of_row;
        logic end_of_frame;
    } dot_t;

    typedef enum {
        LUMA_ANY,
        LUMA_EXTREME,
        LUMA_NEAR_MID,
        LUMA_RAMP
    } luma_mode_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [efd_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [efd_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tlast;
    logic                            m_tuser;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [efd_pkg::APB_ADDR_W-1:0]  paddr = '0;
    logic [efd_pkg::APB_DATA_W-1:0]  pwdata = '0;
    logic [efd_pkg::APB_DATA_W-1:0]  prdata;
    logic                            pready;

    error_diffusion_dither_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    // predictor copy of registers and diffusion state
    logic [efd_pkg::WIDTH_REG_W-1:0]  cfg_width = efd_pkg::WIDTH_RESET;
    logic [efd_pkg::HEIGHT_REG_W-1:0] cfg_height = efd_pkg::HEIGHT_RESET;
    int row_err [efd_pkg::MAX_WIDTH];
    int carry_right = 0;
    int held_below_left = 0;
    int held_below = 0;
    int col_cnt = 0;
    int row_cnt = 0;

    dot_t expected_dots[$];
    int   mismatches = 0;
    int   pixels_sent = 0;
    bit   calm = 1'b0;   // no idling on either side while set
    int   sink_hold = 0;
    int   sink_gap;

    function automatic int clip_err(input int v);
        if (v > ERR_HI) return ERR_HI;
        if (v < ERR_LO) return ERR_LO;
        return v;
    endfunction

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one floyd-steinberg step in 1/16 level units; shares floor via arithmetic shift
    task automatic dither_pixel(input logic [efd_pkg::LUMA_W-1:0] luma, output dot_t d);
        int  w, h, j, v, e;
        bit  last_col, last_row, bit_on;
        w = clamp_dim(int'(cfg_width), efd_pkg::MAX_WIDTH);
        h = clamp_dim(int'(cfg_height), efd_pkg::MAX_HEIGHT);
        j = (col_cnt >= efd_pkg::MAX_WIDTH) ? efd_pkg::MAX_WIDTH - 1 : col_cnt;
        last_col = (j + 1 >= w);
        last_row = (row_cnt + 1 >= h);

        v = int'(luma) * 16 + carry_right;
        if (row_cnt != 0) v += row_err[j];   // first row reads no stored error
        v = clip_err(v);
        bit_on = (v > int'(efd_pkg::THRESHOLD));
        e = v - (bit_on ? int'(efd_pkg::WHITE_LEVEL) : 0);

        carry_right = last_col ? 0 : (e * 7) >>> 4;
        // last row stores nothing for a next row
        if (!last_row) begin
            if (j > 0) row_err[j-1] = clip_err(held_below_left + ((e * 3) >>> 4));
            held_below_left = clip_err(held_below + ((e * 5) >>> 4));
            held_below = last_col ? 0 : e >>> 4;
            if (last_col) row_err[j] = held_below_left;
        end

        if (last_col) begin
            carry_right = 0;
            held_below = 0;
            held_below_left = 0;
            col_cnt = 0;
            row_cnt = last_row ? 0 : row_cnt + 1;
        end else begin
            col_cnt = j + 1;
        end

        d.out_bit = bit_on;
        d.end_of_row = last_col;
        d.end_of_frame = last_col && last_row;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // called at a rising edge; returns at the edge that takes the beat, valid still high
    task automatic send_pixel(input logic [efd_pkg::LUMA_W-1:0] luma);
        int   gap;
        dot_t d;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= luma;
        do @(posedge aclk); while (!s_tready);
        dither_pixel(luma, d);
        expected_dots.push_back(d);
        pixels_sent++;
    endtask

    // stop the input and wait until every expected dot has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_dots.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // setup and access phases, then psel low before the next transfer
    task automatic apb_write(input efd_pkg::reg_idx_t idx,
                             input logic [efd_pkg::APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= efd_pkg::APB_ADDR_W'(int'(idx) * 4);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == efd_pkg::REG_IMAGE_WIDTH) cfg_width = value[efd_pkg::WIDTH_REG_W-1:0];
        else cfg_height = value[efd_pkg::HEIGHT_REG_W-1:0];
        @(posedge aclk);
    endtask

    task automatic apb_check(input efd_pkg::reg_idx_t idx);
        logic [efd_pkg::APB_DATA_W-1:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= efd_pkg::APB_ADDR_W'(int'(idx) * 4);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        want = (idx == efd_pkg::REG_IMAGE_WIDTH) ? efd_pkg::APB_DATA_W'(cfg_width)
                                                 : efd_pkg::APB_DATA_W'(cfg_height);
        if (idx == efd_pkg::REG_IMAGE_WIDTH) begin
            if (prdata[efd_pkg::WIDTH_REG_W-1:0] !== want[efd_pkg::WIDTH_REG_W-1:0])
                report_mismatch($sformatf("width readback %0h, want %0h", prdata, want));
        end else begin
            if (prdata[efd_pkg::HEIGHT_REG_W-1:0] !== want[efd_pkg::HEIGHT_REG_W-1:0])
                report_mismatch($sformatf("height readback %0h, want %0h", prdata, want));
        end
        @(posedge aclk);
    endtask

    // block must be idle: set both registers and read them back
    task automatic set_frame(input int w, input int h);
        drain();
        apb_write(efd_pkg::REG_IMAGE_WIDTH, efd_pkg::APB_DATA_W'(w));
        apb_write(efd_pkg::REG_IMAGE_HEIGHT, efd_pkg::APB_DATA_W'(h));
        apb_check(efd_pkg::REG_IMAGE_WIDTH);
        apb_check(efd_pkg::REG_IMAGE_HEIGHT);
    endtask

    function automatic logic [efd_pkg::LUMA_W-1:0] pick_luma(input luma_mode_t mode,
                                                             input int n);
        case (mode)
            LUMA_EXTREME:  return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            LUMA_NEAR_MID: return efd_pkg::LUMA_W'($urandom_range(118, 137));
            LUMA_RAMP:     return efd_pkg::LUMA_W'(n * 13);
            default:       return efd_pkg::LUMA_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one whole frame at the current settings, so the next one starts clean
    task automatic send_frame(input luma_mode_t mode);
        int count;
        count = clamp_dim(int'(cfg_width), efd_pkg::MAX_WIDTH)
              * clamp_dim(int'(cfg_height), efd_pkg::MAX_HEIGHT);
        for (int n = 0; n < count; n++) send_pixel(pick_luma(mode, n));
    endtask

    // result side: random stalls
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else begin
            sink_gap = pick_gap();
            if (sink_gap == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                sink_hold <= sink_gap - 1;
            end
        end
    end

    // every taken result beat against the oldest expected dot
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_dots.size() == 0) begin
                report_mismatch("result beat with no pixel pending");
            end else begin
                dot_t d;
                d = expected_dots.pop_front();
                if (m_tdata !== efd_pkg::M_TDATA_W'(d.out_bit))
                    report_mismatch($sformatf("m_tdata %0h, want %0h", m_tdata, d.out_bit));
                if (m_tlast !== d.end_of_row)
                    report_mismatch($sformatf("m_tlast %b, want %b", m_tlast, d.end_of_row));
                if (m_tuser !== d.end_of_frame)
                    report_mismatch($sformatf("m_tuser %b, want %b", m_tuser, d.end_of_frame));
            end
        end
    end

    task automatic test_reset_values();
        apb_check(efd_pkg::REG_IMAGE_WIDTH);
        apb_check(efd_pkg::REG_IMAGE_HEIGHT);
    endtask

    // zero sizes act as one; threshold neighbors and full swings in small frames
    task automatic test_tiny_frames();
        set_frame(0, 0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd127);
        set_frame(3, 2);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        set_frame(2, 3);
        send_pixel(8'd127);
        send_pixel(8'd128);
        send_pixel(8'd128);
        send_pixel(8'd127);
        send_pixel(8'd1);
        send_pixel(8'd254);
    endtask

    // shrink width and height while a frame is in flight
    task automatic test_mid_frame_change();
        set_frame(efd_pkg::MAX_WIDTH, 3);
        for (int n = 0; n < 10; n++) send_pixel(efd_pkg::LUMA_W'(n * 29 + 7));
        drain();
        apb_write(efd_pkg::REG_IMAGE_WIDTH, 32'd5);   // column 10 is now past the end
        send_pixel(8'd200);
        send_pixel(8'd60);
        send_pixel(8'd130);
        drain();
        apb_write(efd_pkg::REG_IMAGE_HEIGHT, 32'd1);  // row 1 becomes the last row
        send_pixel(8'd90);
        send_pixel(8'd250);
        send_pixel(8'd3);
    endtask

    // width above the maximum clamps; one full-width row
    task automatic test_widest_rows();
        set_frame(2047, 1);
        send_frame(LUMA_ANY);
    endtask

    // height above the maximum; single-pixel rows, frame closed early by a lower height
    task automatic test_tallest_frame();
        set_frame(1, 8191);
        for (int n = 0; n < 24; n++) send_pixel(pick_luma(LUMA_NEAR_MID, n));
        drain();
        apb_write(efd_pkg::REG_IMAGE_HEIGHT, 32'd1);
        send_pixel(8'd131);
    endtask

    task automatic test_random_frames();
        int start, w, h, r;
        luma_mode_t mode;
        start = pixels_sent;
        while (pixels_sent - start < 240) begin
            r = $urandom_range(0, 99);
            if (r < 65) w = $urandom_range(1, 8);
            else if (r < 88) w = $urandom_range(9, 40);
            else if (r < 94) w = 0;
            else w = $urandom_range(41, 160);
            h = (w > 40) ? $urandom_range(1, 2) : $urandom_range(0, 6);
            set_frame(w, h);
            calm = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 9);
            mode = (r < 5) ? LUMA_ANY : (r < 7) ? LUMA_EXTREME
                 : (r < 9) ? LUMA_NEAR_MID : LUMA_RAMP;
            send_frame(mode);
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_tiny_frames();
        test_mid_frame_change();
        test_widest_rows();
        test_tallest_frame();
        test_random_frames();
        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial begin
        #12_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
